@@ rtl/mexp_pkg.sv @@
// Package: operand width, microcode control word, opcodes and the sequencer program.
package mexp_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int FIELD_WIDTH   = 32;
  localparam int PC_WIDTH      = 3;

  // Modulus used when the configured modulus is zero: arithmetic wraps at 2^W.
  localparam logic [OPERAND_WIDTH:0] WRAP_MODULUS = {1'b1, {OPERAND_WIDTH{1'b0}}};

  // Datapath operations
  localparam logic [1:0] OP_NONE    = 2'd0;
  localparam logic [1:0] OP_REDUCE  = 2'd1;  // base := base mod m
  localparam logic [1:0] OP_MUL_ACC = 2'd2;  // acc  := acc * base mod m
  localparam logic [1:0] OP_MUL_SQ  = 2'd3;  // base := base * base mod m

  // Jump conditions
  localparam logic [2:0] C_NEVER    = 3'd0;
  localparam logic [2:0] C_ALWAYS   = 3'd1;
  localparam logic [2:0] C_NO_INPUT = 3'd2;
  localparam logic [2:0] C_E_ZERO   = 3'd3;
  localparam logic [2:0] C_E_BIT0   = 3'd4;
  localparam logic [2:0] C_E_MORE   = 3'd5;
  localparam logic [2:0] C_OUT_FULL = 3'd6;

  // Step addresses
  localparam logic [PC_WIDTH-1:0] S_ACCEPT = 3'd0;
  localparam logic [PC_WIDTH-1:0] S_TEST_E = 3'd1;
  localparam logic [PC_WIDTH-1:0] S_REDUCE = 3'd2;
  localparam logic [PC_WIDTH-1:0] S_BIT    = 3'd3;
  localparam logic [PC_WIDTH-1:0] S_MULACC = 3'd4;
  localparam logic [PC_WIDTH-1:0] S_SQUARE = 3'd5;
  localparam logic [PC_WIDTH-1:0] S_EMIT   = 3'd6;
  localparam logic [PC_WIDTH-1:0] S_WRAP   = 3'd7;

  typedef struct packed {
    logic [1:0]          op;
    logic                in_ready;
    logic                load_out;
    logic                shift_e;
    logic [2:0]          cond;
    logic [PC_WIDTH-1:0] target;
  } mexp_cw_t;

  // Control store. A step with an operation holds until the multiplier is done,
  // then jumps to target if cond holds, else falls through.
  function automatic mexp_cw_t program_word(input logic [PC_WIDTH-1:0] pc);
    mexp_cw_t cw;
    cw = '{op: OP_NONE, in_ready: 1'b0, load_out: 1'b0, shift_e: 1'b0,
           cond: C_NEVER, target: S_ACCEPT};
    case (pc)
      S_ACCEPT: begin
        cw.in_ready = 1'b1;
        cw.cond     = C_NO_INPUT;
        cw.target   = S_ACCEPT;
      end
      S_TEST_E: begin
        cw.cond   = C_E_ZERO;
        cw.target = S_EMIT;
      end
      S_REDUCE: begin
        cw.op = OP_REDUCE;
      end
      S_BIT: begin
        cw.cond   = C_E_BIT0;
        cw.target = S_SQUARE;
      end
      S_MULACC: begin
        cw.op = OP_MUL_ACC;
      end
      S_SQUARE: begin
        cw.op      = OP_MUL_SQ;
        cw.shift_e = 1'b1;
        cw.cond    = C_E_MORE;
        cw.target  = S_BIT;
      end
      S_EMIT: begin
        cw.load_out = 1'b1;
        cw.cond     = C_OUT_FULL;
        cw.target   = S_EMIT;
      end
      S_WRAP: begin
        cw.cond   = C_ALWAYS;
        cw.target = S_ACCEPT;
      end
      default: begin
        cw.cond   = C_ALWAYS;
        cw.target = S_ACCEPT;
      end
    endcase
    return cw;
  endfunction

endpackage

@@ rtl/mexp_in_if.sv @@
// Interface: input channel carrying base and exponent items.
interface mexp_in_if;
  logic                              valid;
  logic                              ready;
  logic [mexp_pkg::FIELD_WIDTH-1:0]  base_value;
  logic [mexp_pkg::FIELD_WIDTH-1:0]  exponent;

  modport source (output valid, output base_value, output exponent, input ready);
  modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

@@ rtl/mexp_out_if.sv @@
// Interface: output channel carrying power_result items.
interface mexp_out_if;
  logic                              valid;
  logic                              ready;
  logic [mexp_pkg::FIELD_WIDTH-1:0]  power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

@@ rtl/modular_exponentiation_core.sv @@
// Top level: microcoded square-and-multiply modular exponentiation core.
//
// Channels: operand (sink) takes items of base_value and exponent; result
// (source) gives one power_result item per operand item. An item moves on a
// rising clk edge with valid and ready both high. modulus_write/modulus_data
// write the modulus register (low OPERAND_WIDTH bits used; zero means wrap
// at 2^OPERAND_WIDTH). Write it only while the core is idle.
//
// Sequence: a zero exponent goes from the accept step through the exponent
// test straight to the emit step. Otherwise the core reduces the base, then
// for each exponent bit up to the top set bit runs a test step, a multiply
// into the accumulator when the bit is set, and a squaring; the base reduction
// and each modular multiply are a bit-serial shift/add/subtract loop of one
// setup step and one step per operand bit. One item is in work at a time;
// operand.ready is high only in the accept step, which follows the emit and
// wrap steps.
//
// Reset (rst, synchronous): sequencer to the accept step, result register
// empty, modulus back to 1.
// Stall: the finished result sits in an output register; the core accepts
// and works on the next item meanwhile, and holds in its emit step only if
// that register is still full when the next result is ready.
module modular_exponentiation_core (
  input  logic                              clk,
  input  logic                              rst,
  mexp_in_if.sink                           operand,
  mexp_out_if.source                        result,
  input  logic                              modulus_write,
  input  logic [mexp_pkg::FIELD_WIDTH-1:0]  modulus_data
);

  localparam int W  = mexp_pkg::OPERAND_WIDTH;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] LAST_BIT = CW'(W - 1);

  // Architectural registers
  logic [W-1:0] modulus;
  logic [W-1:0] base;
  logic [W-1:0] expo;
  logic [W-1:0] acc;

  // Sequencer
  logic [mexp_pkg::PC_WIDTH-1:0] pc;
  mexp_pkg::mexp_cw_t            cw;

  // Bit-serial multiplier state
  logic          mul_run;
  logic [CW-1:0] mcnt;
  logic [W-1:0]  a_sh;     // multiplier bits, MSB first
  logic [W-1:0]  r;        // partial remainder, always below the modulus

  // Output register
  logic         out_valid;
  logic [W-1:0] out_data;

  assign cw = mexp_pkg::program_word(pc);

  // Effective modulus, W+1 bits so a zero modulus reads as 2^W.
  logic [W:0] mod_ext;
  assign mod_ext = (modulus == '0) ? mexp_pkg::WRAP_MODULUS : {1'b0, modulus};

  // One interleaved step: r := (2r mod m + addend) mod m.
  logic         cur_bit;
  logic [W-1:0] x_op;
  logic [W-1:0] addend;
  logic [W:0]   dbl;
  logic [W:0]   dbl_red;
  logic [W:0]   sum;
  logic [W:0]   sum_red;
  logic [W-1:0] r_next;

  assign cur_bit = a_sh[W-1];
  assign x_op    = base;   // multiplicand is the current square in both multiplies

  always_comb begin
    // Reduction feeds the dividend bits straight in; multiplies add x when the bit is set.
    if (cw.op == mexp_pkg::OP_REDUCE) begin
      addend = W'(cur_bit);
    end else begin
      addend = cur_bit ? x_op : '0;
    end
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
    sum     = {1'b0, dbl_red[W-1:0]} + {1'b0, addend};
    sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
    r_next  = sum_red[W-1:0];
  end

  // Handshakes and step control
  logic in_fire;
  logic out_full;
  logic mul_last;
  logic op_busy;
  logic advance;
  logic cond_true;

  assign operand.ready = cw.in_ready;
  assign in_fire       = operand.valid && cw.in_ready;
  assign out_full      = out_valid && !result.ready;
  assign mul_last      = mul_run && (mcnt == LAST_BIT);
  assign op_busy       = (cw.op != mexp_pkg::OP_NONE) && !mul_last;
  assign advance       = !op_busy;

  always_comb begin
    case (cw.cond)
      mexp_pkg::C_NEVER:    cond_true = 1'b0;
      mexp_pkg::C_ALWAYS:   cond_true = 1'b1;
      mexp_pkg::C_NO_INPUT: cond_true = !in_fire;
      mexp_pkg::C_E_ZERO:   cond_true = (expo == '0);
      mexp_pkg::C_E_BIT0:   cond_true = !expo[0];
      mexp_pkg::C_E_MORE:   cond_true = (expo[W-1:1] != '0);
      mexp_pkg::C_OUT_FULL: cond_true = out_full;
      default:              cond_true = 1'b1;
    endcase
  end

  logic out_load;
  assign out_load = cw.load_out && !out_full;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= mexp_pkg::S_ACCEPT;
      mul_run   <= 1'b0;
      out_valid <= 1'b0;
      modulus   <= W'(1);
    end else begin
      if (modulus_write) begin
        modulus <= modulus_data[W-1:0];
      end
      if (advance) begin
        pc <= cond_true ? cw.target : pc + 1'b1;
      end
      if (cw.op != mexp_pkg::OP_NONE) begin
        mul_run <= !mul_last;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      base <= operand.base_value[W-1:0];
      expo <= operand.exponent[W-1:0];
      acc  <= W'(1);
    end
    if (cw.op != mexp_pkg::OP_NONE) begin
      if (!mul_run) begin
        // setup cycle: load multiplier bits, clear the remainder
        a_sh <= (cw.op == mexp_pkg::OP_MUL_ACC) ? acc : base;
        r    <= '0;
        mcnt <= '0;
      end else begin
        a_sh <= {a_sh[W-2:0], 1'b0};
        r    <= r_next;
        mcnt <= mcnt + 1'b1;
        if (mul_last) begin
          if (cw.op == mexp_pkg::OP_MUL_ACC) begin
            acc <= r_next;
          end else begin
            base <= r_next;
          end
          if (cw.shift_e) begin
            expo <= {1'b0, expo[W-1:1]};
          end
        end
      end
    end
    if (out_load) begin
      out_data <= acc;
    end
  end

  assign result.valid        = out_valid;
  assign result.power_result = mexp_pkg::FIELD_WIDTH'(out_data);

endmodule

@@ rtl/mexp_checker.sv @@
// Checker: port-level assertions for the exponentiation core, bound to the top level.
module mexp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [mexp_pkg::FIELD_WIDTH-1:0]  power_result
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(power_result))
    else $error("result changed while stalled");

  // One item in work at a time: no accept on the cycle after an accept.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("operand ready right after an accept");

  // A new result only appears while the core is busy, never in the accept step.
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_ready)
    else $error("result appeared while waiting for an operand");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (operand.valid),
  .in_ready     (operand.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .power_result (result.power_result)
);
